[hw/rtl/vntd_pkg.sv]
// Shared types and constants for the value noise terrain density pipeline.
// Used by the hash, top and checker modules under hw/rtl; depends on nothing else.
package vntd_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;
  localparam int IndexW = 15;
  localparam int DensW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FREQ  = 2'd0,
    CFG_BASE  = 2'd1,
    CFG_AMP   = 2'd2,
    CFG_SHARP = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] FREQ_RST  = 16'd3277;
  localparam logic [23:0] BASE_RST  = 24'd0;
  localparam logic [23:0] AMP_RST   = 24'd2048;
  localparam logic [23:0] SHARP_RST = 24'd65536;

  localparam logic [31:0] HASH_MUL_X = 32'd1619;
  localparam logic [31:0] HASH_MUL_Z = 32'd31337;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic [31:0] HASH_BIAS  = 32'h4000_0000;

  localparam logic [DensW-1:0] DENS_ONE  = 17'd65536;
  localparam logic [DensW-1:0] DENS_HALF = 17'd32768;

  typedef struct packed {
    logic              valid;
    logic [IndexW-1:0] index;
  } sideband_t;

endpackage

[hw/rtl/vntd_hash.sv]
// Four-stage pipelined 32-bit lattice hash producing a signed Q1.30 value.
// Depends on vntd_pkg for the hash constants.
module vntd_hash (
  input  logic               clk,
  input  logic [31:0]        ix,
  input  logic [31:0]        iz,
  output logic signed [31:0] val_r
);

  logic [31:0] seed;
  logic [31:0] n1_r, n2_r, n3_r, sq_r, t_r;
  logic [31:0] m;

  always_comb begin
    seed = ix * vntd_pkg::HASH_MUL_X + iz * vntd_pkg::HASH_MUL_Z;
    m    = n3_r * t_r + vntd_pkg::HASH_C3;
  end

  always_ff @(posedge clk) begin
    n1_r  <= (seed << 13) ^ seed;
    sq_r  <= n1_r * n1_r;
    n2_r  <= n1_r;
    t_r   <= sq_r * vntd_pkg::HASH_C1 + vntd_pkg::HASH_C2;
    n3_r  <= n2_r;
    val_r <= $signed({1'b0, m[30:0]} - vntd_pkg::HASH_BIAS);
  end

endmodule

[hw/rtl/vntd_ease.sv]
// Two-stage smoothstep weight on a Q0.16 fraction.
// Self-contained; no package items are needed.
module vntd_ease (
  input  logic        clk,
  input  logic [15:0] frac,
  output logic [16:0] u_r
);

  logic [31:0] ff_r;
  logic [17:0] w_r;
  logic [49:0] prod;

  assign prod = 50'(ff_r) * 50'(w_r);

  always_ff @(posedge clk) begin
    ff_r <= 32'(frac) * 32'(frac);
    w_r  <= 18'h30000 - {1'b0, frac, 1'b0};
    u_r  <= prod[48:32];
  end

endmodule

[hw/rtl/vntd_lerp.sv]
// Two-stage linear blend a + floor(t * (b - a) / 2^16) on signed Q1.30 values.
// Self-contained; no package items are needed.
module vntd_lerp (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic [16:0]        t,
  output logic signed [31:0] y_r
);

  logic signed [32:0] diff;
  logic signed [31:0] a_r;
  logic signed [50:0] prod_r;
  logic signed [34:0] step;

  assign diff = 33'(b) - 33'(a);
  assign step = 35'(prod_r >>> 16);

  always_ff @(posedge clk) begin
    a_r    <= a;
    prod_r <= 51'(diff) * 51'($signed({1'b0, t}));
    y_r    <= 32'(35'(a_r) + step);
  end

endmodule

[hw/rtl/value_noise_terrain_density.sv]
// Value noise terrain density: one corner in per cycle while busy is low, one result per corner.
// The result strobe is the valid bit of the 14th register stage, aligned with the density register.
// Throughput is one corner per cycle while busy is low, set by the fully pipelined hash and multiply stages.
// Reset is synchronous and active low; it clears the valid bits and restores the registers.
// The receiver cannot stall, so busy is high only during reset and in the cycle right after it.
module value_noise_terrain_density #(
  parameter int CHUNK_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [18:0]            in_chunk_x,
  input  logic signed [18:0]            in_chunk_y,
  input  logic signed [18:0]            in_chunk_z,
  input  logic [4:0]                    in_local_x,
  input  logic [4:0]                    in_local_y,
  input  logic [4:0]                    in_local_z,
  output logic                          out_valid,
  output logic [vntd_pkg::IndexW-1:0]   out_corner_index,
  output logic [vntd_pkg::DensW-1:0]    out_density,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vntd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vntd_pkg::CfgDataW-1:0] cfg_data
);

  localparam int WW = 19 + $clog2(CHUNK_SIZE + 1) + 1;
  localparam int PW = WW + 17;
  localparam int IW = PW - 16;
  localparam int DW = WW + 10;
  localparam int Lat = 14;
  localparam logic signed [WW-1:0] CsW = WW'(CHUNK_SIZE);
  localparam logic [vntd_pkg::IndexW-1:0] CsI = vntd_pkg::IndexW'(CHUNK_SIZE);

  logic        [15:0] freq_r;
  logic signed [23:0] base_r;
  logic        [23:0] amp_r;
  logic        [23:0] sharp_r;
  logic               busy_r;

  vntd_pkg::sideband_t sb_r [Lat];
  vntd_pkg::sideband_t sb_nxt;
  logic signed [WW-1:0] wy_r [Lat-3];

  logic signed [WW-1:0] wx_r, wz_r;
  logic signed [PW-1:0] px_r, pz_r;
  logic signed [IW-1:0] ix, iz;
  logic [31:0] ix0, iz0, ix1, iz1;
  logic signed [31:0] v00, v10, v01, v11, lo, hi, nv;
  logic [16:0] ux, uz, ux_d_r [2], uz_d_r [4];
  logic signed [56:0] nvamp_r;
  logic signed [26:0] hv;
  logic signed [27:0] height;
  logic signed [DW-1:0] dist_r;
  logic signed [DW+24:0] dprod_r;
  logic signed [DW+16:0] dq;
  logic [vntd_pkg::DensW-1:0] dens_nxt, dens_r;

  assign busy = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      freq_r  <= vntd_pkg::FREQ_RST;
      base_r  <= vntd_pkg::BASE_RST;
      amp_r   <= vntd_pkg::AMP_RST;
      sharp_r <= vntd_pkg::SHARP_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (vntd_pkg::cfg_idx_t'(cfg_index))
          vntd_pkg::CFG_FREQ:  freq_r  <= cfg_data[15:0];
          vntd_pkg::CFG_BASE:  base_r  <= $signed(cfg_data);
          vntd_pkg::CFG_AMP:   amp_r   <= cfg_data;
          vntd_pkg::CFG_SHARP: sharp_r <= cfg_data;
        endcase
      end
    end
  end

  always_comb begin
    sb_nxt.valid = start && !busy_r;
    sb_nxt.index = vntd_pkg::IndexW'(in_local_x)
                 + CsI * (vntd_pkg::IndexW'(in_local_y) + CsI * vntd_pkg::IndexW'(in_local_z));
  end

  always_ff @(posedge clk) begin
    sb_r[0].index <= sb_nxt.index;
    for (int i = 1; i < Lat; i++) sb_r[i].index <= sb_r[i-1].index;
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) sb_r[i].valid <= 1'b0;
    end else begin
      sb_r[0].valid <= sb_nxt.valid;
      for (int i = 1; i < Lat; i++) sb_r[i].valid <= sb_r[i-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    wx_r <= WW'(in_chunk_x) * CsW + WW'(in_local_x);
    wz_r <= WW'(in_chunk_z) * CsW + WW'(in_local_z);
    wy_r[0] <= WW'(in_chunk_y) * CsW + WW'(in_local_y);
    for (int i = 1; i < Lat - 3; i++) wy_r[i] <= wy_r[i-1];
    px_r <= PW'(wx_r) * PW'($signed({1'b0, freq_r}));
    pz_r <= PW'(wz_r) * PW'($signed({1'b0, freq_r}));
    ux_d_r[0] <= ux;
    ux_d_r[1] <= ux_d_r[0];
    uz_d_r[0] <= uz;
    for (int i = 1; i < 4; i++) uz_d_r[i] <= uz_d_r[i-1];
  end

  always_comb begin
    ix  = IW'(px_r >>> 16);
    iz  = IW'(pz_r >>> 16);
    ix0 = 32'(ix);
    iz0 = 32'(iz);
    ix1 = ix0 + 32'd1;
    iz1 = iz0 + 32'd1;
  end

  vntd_hash u_h00 (.clk(clk), .ix(ix0), .iz(iz0), .val_r(v00));
  vntd_hash u_h10 (.clk(clk), .ix(ix1), .iz(iz0), .val_r(v10));
  vntd_hash u_h01 (.clk(clk), .ix(ix0), .iz(iz1), .val_r(v01));
  vntd_hash u_h11 (.clk(clk), .ix(ix1), .iz(iz1), .val_r(v11));

  vntd_ease u_ex (.clk(clk), .frac(px_r[15:0]), .u_r(ux));
  vntd_ease u_ez (.clk(clk), .frac(pz_r[15:0]), .u_r(uz));

  vntd_lerp u_lo (.clk(clk), .a(v00), .b(v10), .t(ux_d_r[1]), .y_r(lo));
  vntd_lerp u_hi (.clk(clk), .a(v01), .b(v11), .t(ux_d_r[1]), .y_r(hi));
  vntd_lerp u_nv (.clk(clk), .a(lo), .b(hi), .t(uz_d_r[3]), .y_r(nv));

  always_comb begin
    hv     = 27'(nvamp_r >>> 30);
    height = 28'(base_r) + 28'(hv);
    dq     = (DW+17)'(dprod_r >>> 8) + (DW+17)'(vntd_pkg::DENS_HALF);
    if (dq < 0) begin
      dens_nxt = '0;
    end else if (dq > (DW+17)'(vntd_pkg::DENS_ONE)) begin
      dens_nxt = vntd_pkg::DENS_ONE;
    end else begin
      dens_nxt = dq[vntd_pkg::DensW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    nvamp_r <= 57'(nv) * 57'($signed({1'b0, amp_r}));
    dist_r  <= DW'(height) - (DW'(wy_r[Lat-4]) <<< 8);
    dprod_r <= (DW+25)'(dist_r) * (DW+25)'($signed({1'b0, sharp_r}));
    dens_r  <= dens_nxt;
  end

  assign out_valid        = sb_r[Lat-1].valid;
  assign out_corner_index = sb_r[Lat-1].index;
  assign out_density      = dens_r;

endmodule

[hw/rtl/vntd_checker.sv]
// Port-level checker for value_noise_terrain_density, with its bind statement.
// Depends on vntd_pkg for the density limit.
module vntd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [vntd_pkg::DensW-1:0]  out_density
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result strobe seen right after reset.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##14 out_valid)
    else $error("Accepted corner produced no result after 14 cycles.");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 14))
    else $error("Result strobe without a matching transfer.");

  a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_density <= vntd_pkg::DENS_ONE))
    else $error("Density beyond fully solid.");

endmodule

bind value_noise_terrain_density vntd_checker u_vntd_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_density(out_density)
);

[bench/value_noise_terrain_density_checker.sv]
// Checker for value_noise_terrain_density: watches the corner, result and register channels.
// Predicts each density from its own copy of the registers and compares in order.
// Depends on vntd_pkg for the register index codes and the hash constants.
module value_noise_terrain_density_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [18:0]            in_chunk_x,
  input  logic signed [18:0]            in_chunk_y,
  input  logic signed [18:0]            in_chunk_z,
  input  logic [4:0]                    in_local_x,
  input  logic [4:0]                    in_local_y,
  input  logic [4:0]                    in_local_z,
  input  logic                          out_valid,
  input  logic [vntd_pkg::IndexW-1:0]   out_corner_index,
  input  logic [vntd_pkg::DensW-1:0]    out_density,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [vntd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vntd_pkg::CfgDataW-1:0] cfg_data,
  output int                            pending,
  output int                            fail_count
);

  localparam longint Chunk = 32;

  typedef struct {
    logic [vntd_pkg::IndexW-1:0] index;
    logic [vntd_pkg::DensW-1:0]  density;
  } corner_result_t;

  corner_result_t expected_corners[$];
  logic [15:0] freq;
  logic [23:0] base, amp, sharp;

  function automatic longint lattice(longint ix, longint iz);
    logic [31:0] n;
    n = ix[31:0] * vntd_pkg::HASH_MUL_X + iz[31:0] * vntd_pkg::HASH_MUL_Z;
    n = (n << 13) ^ n;
    n = n * (n * n * vntd_pkg::HASH_C1 + vntd_pkg::HASH_C2) + vntd_pkg::HASH_C3;
    return longint'({33'd0, n[30:0]}) - longint'(vntd_pkg::HASH_BIAS);
  endfunction

  function automatic longint smooth(longint f);
    return (f * f * ((longint'(3) << 16) - 2 * f)) >>> 32;
  endfunction

  function automatic longint mix(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic logic [vntd_pkg::DensW-1:0] corner_density(longint wx, longint wy,
                                                                longint wz);
    longint px, pz, ix, iz, ux, uz, lo, hi, nv, height, gap, d;
    px = wx * longint'(freq);
    pz = wz * longint'(freq);
    ix = px >>> 16;
    iz = pz >>> 16;
    ux = smooth(px & 64'hffff);
    uz = smooth(pz & 64'hffff);
    lo = mix(lattice(ix, iz), lattice(ix + 1, iz), ux);
    hi = mix(lattice(ix, iz + 1), lattice(ix + 1, iz + 1), ux);
    nv = mix(lo, hi, uz);
    height = longint'(signed'(base)) + ((nv * longint'(amp)) >>> 30);
    gap = height - wy * 256;
    d = 32768 + ((gap * longint'(sharp)) >>> 8);
    if (d < 0) d = 0;
    if (d > 65536) d = 65536;
    return d[vntd_pkg::DensW-1:0];
  endfunction

  assign pending = expected_corners.size();

  always @(posedge clk) begin
    corner_result_t e;
    longint wx, wy, wz, idx;
    int errs;
    errs = 0;
    if (!rst_n) begin
      freq <= vntd_pkg::FREQ_RST;
      base <= vntd_pkg::BASE_RST;
      amp <= vntd_pkg::AMP_RST;
      sharp <= vntd_pkg::SHARP_RST;
      fail_count <= 0;
      expected_corners.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (vntd_pkg::cfg_idx_t'(cfg_index))
          vntd_pkg::CFG_FREQ:  freq <= cfg_data[15:0];
          vntd_pkg::CFG_BASE:  base <= cfg_data;
          vntd_pkg::CFG_AMP:   amp <= cfg_data;
          vntd_pkg::CFG_SHARP: sharp <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        wx = longint'(in_chunk_x) * Chunk + longint'(in_local_x);
        wy = longint'(in_chunk_y) * Chunk + longint'(in_local_y);
        wz = longint'(in_chunk_z) * Chunk + longint'(in_local_z);
        idx = longint'(in_local_x) + Chunk * (longint'(in_local_y) + Chunk * longint'(in_local_z));
        e.index = idx[vntd_pkg::IndexW-1:0];
        e.density = corner_density(wx, wy, wz);
        expected_corners.push_back(e);
      end
      if (out_valid) begin
        if (expected_corners.size() == 0) begin
          $error("unexpected result: corner_index %0d density %0d",
                 out_corner_index, out_density);
          errs++;
        end else begin
          e = expected_corners.pop_front();
          if (e.index !== out_corner_index) begin
            $error("corner_index: expected %0d, got %0d", e.index, out_corner_index);
            errs++;
          end
          if (e.density !== out_density) begin
            $error("density: expected %0d, got %0d", e.density, out_density);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

[bench/value_noise_terrain_density_tb.sv]
// Testbench top for value_noise_terrain_density: clock, reset, corner and register stimulus.
// Depends on vntd_pkg, the block and value_noise_terrain_density_checker.
module value_noise_terrain_density_tb;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [18:0] in_chunk_x = 0, in_chunk_y = 0, in_chunk_z = 0;
  logic [4:0] in_local_x = 0, in_local_y = 0, in_local_z = 0;
  logic out_valid;
  logic [vntd_pkg::IndexW-1:0] out_corner_index;
  logic [vntd_pkg::DensW-1:0] out_density;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [vntd_pkg::CfgIdxW-1:0] cfg_index = vntd_pkg::CFG_FREQ;
  logic [vntd_pkg::CfgDataW-1:0] cfg_data = 0;
  int pending, fail_count;
  int cycles = 0;
  int idle_pct = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  value_noise_terrain_density dut (.*);
  value_noise_terrain_density_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("value_noise_terrain_density_tb: errors");
      $finish;
    end
  end

  task automatic send_corner(logic [18:0] cx, cy, cz, logic [4:0] lx, ly, lz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_chunk_x <= cx;
    in_chunk_y <= cy;
    in_chunk_z <= cz;
    in_local_x <= lx;
    in_local_y <= ly;
    in_local_z <= lz;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(vntd_pkg::cfg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [18:0] rand_chunk(int lo, int hi);
    if ($urandom_range(1)) return 19'($urandom);
    return 19'($urandom_range(hi - lo) + lo);
  endfunction

  initial begin
    logic [15:0] freqs[7] = '{16'd3277, 16'd0, 16'd65535, 16'd65535, 16'd1000, 16'd30000,
                              16'd3277};
    logic [23:0] bases[7] = '{24'd0, 24'd0, 24'h800000, 24'h7fffff, 24'd2560, -24'sd512, 24'd0};
    logic [23:0] amps[7] = '{24'd2048, 24'd2048, 24'hffffff, 24'd0, 24'd4096, 24'hffffff,
                             24'd2048};
    logic [23:0] sharps[7] = '{24'd65536, 24'd65536, 24'hffffff, 24'd0, 24'd8192, 24'd300,
                               24'd65536};
    int pcts[7] = '{0, 49, 0, 18, 49, 18, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_corner(19'h40000, 19'h40000, 19'h40000, 5'd0, 5'd0, 5'd0);
    send_corner(19'h3ffff, 19'h3ffff, 19'h3ffff, 5'd31, 5'd31, 5'd31);
    send_corner(19'h40000, 19'h3ffff, 19'h3ffff, 5'd31, 5'd0, 5'd31);
    send_corner(19'h3ffff, 19'h40000, 19'h40000, 5'd0, 5'd31, 5'd0);
    send_corner(19'd0, 19'd0, 19'd0, 5'd0, 5'd0, 5'd0);
    send_corner(19'h7ffff, 19'h7ffff, 19'h7ffff, 5'd31, 5'd31, 5'd31);
    send_corner(19'd1, 19'd0, 19'd1, 5'd31, 5'd16, 5'd31);
    send_corner(19'h55555, 19'h2aaaa, 19'h55555, 5'd21, 5'd10, 5'd21);
    send_corner(19'h2aaaa, 19'h55555, 19'h2aaaa, 5'd10, 5'd21, 5'd10);
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      if (ph > 0) begin
        write_reg(vntd_pkg::CFG_FREQ, {8'd0, freqs[ph]});
        write_reg(vntd_pkg::CFG_BASE, bases[ph]);
        write_reg(vntd_pkg::CFG_AMP, amps[ph]);
        write_reg(vntd_pkg::CFG_SHARP, sharps[ph]);
      end
      idle_pct = pcts[ph];
      if (ph == 2 || ph == 3) begin
        send_corner(19'h40000, 19'h40000, 19'h40000, 5'd0, 5'd0, 5'd0);
        send_corner(19'h3ffff, 19'h3ffff, 19'h3ffff, 5'd31, 5'd31, 5'd31);
      end
      for (int i = 0; i < 220; i++) begin
        send_corner(rand_chunk(-40, 40), rand_chunk(-2, 1), rand_chunk(-40, 40),
                    5'($urandom), 5'($urandom), 5'($urandom));
        if ($urandom_range(7) == 0) idle_pct = pcts[ph] == 0 ? 0 : $urandom_range(1) * 49;
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("value_noise_terrain_density_tb: clean");
    end else begin
      $display("value_noise_terrain_density_tb: errors");
    end
    $finish;
  end
endmodule
